// ===== src/nfpa_pkg.sv =====
// Shared types and constants of the next-fit page allocator.
package nfpa_pkg;

    localparam int PAGE_W     = 11;  // page number inside the block (window end needs 11 bits)
    localparam int IDX_W      = 10;  // page index on the ports
    localparam int ROW_W      = 32;  // pages per bitmap row
    localparam int OFF_W      = 5;   // page offset inside a row
    localparam int ROWN_W     = PAGE_W - OFF_W;
    localparam int FUNC_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int LO_W       = 10;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PERM  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_USER_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USER_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL     = 2'd2;

    localparam logic [LO_W-1:0]   USER_LOW_RST  = 10'd256;
    localparam logic [PAGE_W-1:0] USER_HIGH_RST = 11'd1024;
    localparam logic [PAGE_W-1:0] TOTAL_RST     = 11'd1024;
    localparam logic [PAGE_W-1:0] PTR_RST       = 11'd256;

    typedef struct packed {
        logic clr_wr;       // clearing pass: write zero row
        logic load_req;     // capture accepted word
        logic res_clr;      // preset result to failure
        logic start_alloc;  // wrap pointer, point at first scan row
        logic start_mod;    // point at row of page_index
        logic rd;           // read current row
        logic phase_b;      // second half of the circular scan
        logic row_inc;
        logic to_b;         // move to the first row of the window
        logic take;         // mark hit page allocated, move pointer
        logic mod_wr;       // write back free or permission change
        logic push;         // load output register
    } nfpa_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_alloc;
        logic is_mod;
        logic win_ok;
        logic idx_ok;
        logic hit;
        logic row_last;
        logic b_empty;
    } nfpa_sts_t;

endpackage

// ===== src/nfpa_req_if.sv =====
// Request channel: operation code, page index and permission bit.
interface nfpa_req_if;
    import nfpa_pkg::*;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  page_index;
    logic              usable;

    modport source (output valid, func, page_index, usable, input ready);
    modport sink   (input valid, func, page_index, usable, output ready);
endinterface

// ===== src/nfpa_rsp_if.sv =====
// Response channel: granted page and success flag.
interface nfpa_rsp_if;
    import nfpa_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] granted_page;
    logic             granted;

    modport source (output valid, granted_page, granted, input ready);
    modport sink   (input valid, granted_page, granted, output ready);
endinterface

// ===== src/nfpa_cfg_if.sv =====
// Configuration write channel: register index and data.
interface nfpa_cfg_if;
    import nfpa_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/nfpa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module nfpa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/nfpa_ctrl.sv =====
// Sequencer: clearing pass, request decode, row-by-row scan and response hand-off.
module nfpa_ctrl import nfpa_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  logic      rsp_ready,
    output logic      rsp_valid,
    input  nfpa_sts_t sts,
    output nfpa_cmd_t cmd
);

    typedef enum logic [9:0] {
        ST_CLEAR  = 10'b00_0000_0001,
        ST_IDLE   = 10'b00_0000_0010,
        ST_DECODE = 10'b00_0000_0100,
        ST_A_RD   = 10'b00_0000_1000,
        ST_A_EV   = 10'b00_0001_0000,
        ST_B_RD   = 10'b00_0010_0000,
        ST_B_EV   = 10'b00_0100_0000,
        ST_M_RD   = 10'b00_1000_0000,
        ST_M_WR   = 10'b01_0000_0000,
        ST_RESP   = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.res_clr = 1'b1;
                if (sts.is_alloc && sts.win_ok)
                begin
                    cmd.start_alloc = 1'b1;
                    state_next      = ST_A_RD;
                end
                else if (sts.is_mod && sts.idx_ok)
                begin
                    cmd.start_mod = 1'b1;
                    state_next    = ST_M_RD;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_A_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_A_EV;
            end
            ST_A_EV:
            begin
                if (sts.hit)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_RESP;
                end
                else if (sts.row_last)
                begin
                    // wrap to the window start unless the pointer already sits there
                    if (sts.b_empty)
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        cmd.to_b   = 1'b1;
                        state_next = ST_B_RD;
                    end
                end
                else
                begin
                    cmd.row_inc = 1'b1;
                    state_next  = ST_A_RD;
                end
            end
            ST_B_RD:
            begin
                cmd.rd      = 1'b1;
                cmd.phase_b = 1'b1;
                state_next  = ST_B_EV;
            end
            ST_B_EV:
            begin
                cmd.phase_b = 1'b1;
                if (sts.hit)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_RESP;
                end
                else if (sts.row_last)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    cmd.row_inc = 1'b1;
                    state_next  = ST_B_RD;
                end
            end
            ST_M_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_M_WR;
            end
            ST_M_WR:
            begin
                cmd.mod_wr = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.push)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// ===== src/nfpa_dpath.sv =====
// Datapath: configuration registers, search pointer, bitmap RAM and row scan logic.
module nfpa_dpath import nfpa_pkg::*; #(
    parameter int NUM_PAGES = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  nfpa_cmd_t             cmd,
    output nfpa_sts_t             sts,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [FUNC_W-1:0]     req_func,
    input  logic [IDX_W-1:0]      req_page_index,
    input  logic                  req_usable,
    output logic [IDX_W-1:0]      rsp_granted_page,
    output logic                  rsp_granted
);

    localparam int NROWS = (NUM_PAGES + ROW_W - 1) / ROW_W;
    localparam int RAW   = (NROWS > 1) ? $clog2(NROWS) : 1;

    // configuration
    logic [LO_W-1:0]   lo_reg;
    logic [PAGE_W-1:0] hi_reg, total_reg;

    // request word
    logic [FUNC_W-1:0] func_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              use_reg;

    logic [PAGE_W-1:0] ptr_reg, ptr_next;
    logic [PAGE_W-1:0] start_reg;
    logic [ROWN_W-1:0] row_reg, row_next;
    logic [RAW-1:0]    clr_cnt_reg;
    logic [IDX_W-1:0]  res_page_reg, out_page_reg;
    logic              res_grant_reg, out_grant_reg;

    logic [PAGE_W-1:0] lo_ext, hi_sat, p_wrap, lb, ub_last, hit_page, hit_next;
    logic [ROW_W-1:0]  alloc_row, usable_row, lo_mask, hi_mask, cand;
    logic [OFF_W-1:0]  hit_off, idx_off;
    logic [2*ROW_W-1:0] rdata, wdata;
    logic [RAW-1:0]    waddr;
    logic              we;

    function automatic logic [OFF_W-1:0] first_set(input logic [ROW_W-1:0] v);
        logic [OFF_W-1:0] pos;
        logic             found;
        pos   = '0;
        found = 1'b0;
        for (int k = 0; k < ROW_W; k++)
        begin
            if (v[k] && !found)
            begin
                pos   = OFF_W'(k);
                found = 1'b1;
            end
        end
        return pos;
    endfunction

    // window bounds
    assign lo_ext = {1'b0, lo_reg};
    assign hi_sat = (32'(hi_reg) > NUM_PAGES) ? PAGE_W'(NUM_PAGES) : hi_reg;
    assign p_wrap = (ptr_reg < lo_ext || ptr_reg >= hi_sat) ? lo_ext : ptr_reg;

    // first pass covers [start, hi), second pass [lo, start)
    assign lb      = cmd.phase_b ? lo_ext : start_reg;
    assign ub_last = cmd.phase_b ? (start_reg - PAGE_W'(1)) : (hi_sat - PAGE_W'(1));

    assign alloc_row  = rdata[ROW_W-1:0];
    assign usable_row = rdata[2*ROW_W-1:ROW_W];

    assign lo_mask = (row_reg == lb[PAGE_W-1:OFF_W]) ? ({ROW_W{1'b1}} << lb[OFF_W-1:0])
                                                     : {ROW_W{1'b1}};
    assign hi_mask = (row_reg == ub_last[PAGE_W-1:OFF_W])
                     ? ~(({ROW_W{1'b1}} << ub_last[OFF_W-1:0]) << 1)
                     : {ROW_W{1'b1}};
    assign cand     = usable_row & ~alloc_row & lo_mask & hi_mask;
    assign hit_off  = first_set(cand);
    assign hit_page = {row_reg, hit_off};
    assign hit_next = hit_page + PAGE_W'(1);
    assign idx_off  = idx_reg[OFF_W-1:0];

    assign sts.clr_last = (clr_cnt_reg == RAW'(NROWS - 1));
    assign sts.is_alloc = (func_reg == FUNC_ALLOC);
    assign sts.is_mod   = (func_reg == FUNC_FREE) || (func_reg == FUNC_PERM);
    assign sts.win_ok   = !(total_reg < hi_reg) && (lo_ext < hi_sat);
    assign sts.idx_ok   = (32'(idx_reg) < NUM_PAGES);
    assign sts.hit      = |cand;
    assign sts.row_last = (row_reg == ub_last[PAGE_W-1:OFF_W]);
    assign sts.b_empty  = (start_reg == lo_ext);

    // bitmap write port
    always_comb
    begin
        wdata = rdata;
        if (cmd.clr_wr)
        begin
            wdata = '0;
        end
        else if (cmd.take)
        begin
            wdata[hit_off] = 1'b1;
        end
        else if (func_reg == FUNC_FREE)
        begin
            wdata[idx_off] = 1'b0;
        end
        else
        begin
            wdata[ROW_W + 32'(idx_off)] = use_reg;
        end
    end

    assign we    = cmd.clr_wr || cmd.take || cmd.mod_wr;
    assign waddr = cmd.clr_wr ? clr_cnt_reg : RAW'(row_reg);

    nfpa_ram #(
        .WIDTH (2 * ROW_W),
        .DEPTH (NROWS)
    ) u_bitmap (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.rd),
        .raddr (RAW'(row_reg)),
        .rdata (rdata)
    );

    always_comb
    begin
        row_next = row_reg;
        if (cmd.start_alloc)
        begin
            row_next = p_wrap[PAGE_W-1:OFF_W];
        end
        else if (cmd.start_mod)
        begin
            row_next = ROWN_W'(idx_reg[IDX_W-1:OFF_W]);
        end
        else if (cmd.to_b)
        begin
            row_next = lo_ext[PAGE_W-1:OFF_W];
        end
        else if (cmd.row_inc)
        begin
            row_next = row_reg + ROWN_W'(1);
        end
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.start_alloc)
        begin
            ptr_next = p_wrap;
        end
        else if (cmd.take)
        begin
            ptr_next = (hit_next >= hi_sat) ? lo_ext : hit_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg      <= USER_LOW_RST;
            hi_reg      <= USER_HIGH_RST;
            total_reg   <= TOTAL_RST;
            ptr_reg     <= PTR_RST;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_USER_LOW:  lo_reg    <= cfg_data[LO_W-1:0];
                    CFG_USER_HIGH: hi_reg    <= cfg_data;
                    CFG_TOTAL:     total_reg <= cfg_data;
                    default:       ;
                endcase
            end
            ptr_reg <= ptr_next;
            if (cmd.clr_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + RAW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            func_reg <= req_func;
            idx_reg  <= req_page_index;
            use_reg  <= req_usable;
        end
        if (cmd.start_alloc)
        begin
            start_reg <= p_wrap;
        end
        row_reg <= row_next;
        if (cmd.res_clr)
        begin
            res_page_reg  <= '0;
            res_grant_reg <= 1'b0;
        end
        else if (cmd.take)
        begin
            res_page_reg  <= hit_page[IDX_W-1:0];
            res_grant_reg <= 1'b1;
        end
        if (cmd.push)
        begin
            out_page_reg  <= res_page_reg;
            out_grant_reg <= res_grant_reg;
        end
    end

    assign rsp_granted_page = out_page_reg;
    assign rsp_granted      = out_grant_reg;

endmodule

// ===== src/next_fit_page_allocator_core.sv =====
// Top level of the next-fit page allocator.
// Next-fit page allocator. Keeps a usable bit and an allocated bit for each of
// NUM_PAGES pages in one bitmap RAM of 32-page rows, plus a next-fit pointer.
// Every request word gives exactly one response word. Allocate scans the user
// window circularly from the pointer, one row at a time (RAM read, then
// evaluate), and visits at most the window's rows plus one. Free and set
// permission are a read-modify-write of one row; requests refused at decode
// go straight to the response. One request is worked on at a time; the
// response sits in an output register, so the next request is taken while it
// waits, and that request then holds in its response state until the waiting
// word is taken. After reset the block clears all ceil(NUM_PAGES/32) rows of
// the bitmap, one row a cycle, before it takes the first request; configuration
// writes are taken at any time.
module next_fit_page_allocator_core import nfpa_pkg::*; #(
    parameter int NUM_PAGES = 1024
) (
    input  logic           clk,
    input  logic           rst_n,
    nfpa_req_if.sink       req,
    nfpa_rsp_if.source     rsp,
    nfpa_cfg_if.sink       cfg
);

    nfpa_cmd_t cmd;
    nfpa_sts_t sts;

    assign cfg.ready = 1'b1;

    nfpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp.valid),
        .sts       (sts),
        .cmd       (cmd)
    );

    nfpa_dpath #(
        .NUM_PAGES (NUM_PAGES)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_valid        (cfg.valid),
        .cfg_index        (cfg.index),
        .cfg_data         (cfg.data),
        .req_func         (req.func),
        .req_page_index   (req.page_index),
        .req_usable       (req.usable),
        .rsp_granted_page (rsp.granted_page),
        .rsp_granted      (rsp.granted)
    );

endmodule

// ===== src/nfpa_checker.sv =====
// Port-level assertions for the page allocator, bound to the top level.
module nfpa_checker import nfpa_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input logic [IDX_W-1:0] rsp_granted_page,
    input logic             rsp_granted
);

    // a waiting response word is not withdrawn
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped before it was taken");

    // a failed or non-allocate response reports page zero
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_granted |-> rsp_granted_page == '0)
        else $error("nonzero page on a failed response");

    // one request at a time: busy right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in work");

    // a response needs at least the decode cycle after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !$rose(rsp_valid))
        else $error("response appeared too early");

endmodule

bind next_fit_page_allocator_core nfpa_checker u_nfpa_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_granted_page (rsp.granted_page),
    .rsp_granted      (rsp.granted)
);
